// File: rtl/core/can_bts_pkg.sv
`timescale 1ns / 1ps

package can_bts_pkg;

  // Field widths
  localparam int unsigned CLK_W   = 30;
  localparam int unsigned RATE_W  = 24;
  localparam int unsigned SP_W    = 10;
  localparam int unsigned PRE_W   = 11;
  localparam int unsigned SEG1_W  = 9;
  localparam int unsigned SEG2_W  = 8;
  localparam int unsigned SJW_W   = 8;
  localparam int unsigned DIV_W   = 30;
  localparam int unsigned CFG_IDX_W = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_FREQ  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESC_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG1_LIMIT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG2_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SJW_LIMIT   = 3'd4;

  // Register reset values
  localparam logic [CLK_W-1:0]  CLOCK_FREQ_RST  = 30'd48000000;
  localparam logic [PRE_W-1:0]  PRESC_LIMIT_RST = 11'd1024;
  localparam logic [SEG1_W-1:0] SEG1_LIMIT_RST  = 9'd16;
  localparam logic [SEG2_W-1:0] SEG2_LIMIT_RST  = 8'd8;
  localparam logic [SJW_W-1:0]  SJW_LIMIT_RST   = 8'd4;

  // Arithmetic constants
  localparam logic [SP_W-1:0]  SP_MIN        = 10'd500;
  localparam logic [SP_W-1:0]  SP_MAX        = 10'd950;
  localparam logic [SP_W-1:0]  PERMILLE      = 10'd1000;
  localparam logic [19:0]      HALF_PERMILLE = 20'd500;
  localparam logic [DIV_W-1:0] MIN_QUANTA    = 30'd4;
  // No timing with this many quanta or more fits the segment registers
  localparam logic [DIV_W-1:0] QUANTA_CAP    = 30'd1024;
  // x / 1000 as (x * SEG_RECIP) >> SEG_SHIFT, exact for x below 2^22
  localparam logic [19:0]      SEG_RECIP     = 20'd536871;
  localparam int unsigned      SEG_SHIFT     = 29;

  // Divider operand select
  localparam logic [1:0] DIV_SEL_CLK = 2'd0;
  localparam logic [1:0] DIV_SEL_ASP = 2'd2;

  typedef struct packed {
    logic       load_item;
    logic       step;
    logic       div_start;
    logic [1:0] div_sel;
    logic       load_total;
    logic       load_prod;
    logic       load_s2;
    logic       push;
    logic       push_found;
  } cmd_t;

  typedef struct packed {
    logic reject;
    logic p_over;
    logic denom_over;
    logic div_busy;
    logic exact;
    logic tot_small;
    logic tot_big;
    logic seg_bad;
    logic out_full;
  } status_t;

endpackage

// File: rtl/core/can_bts_div.sv
`timescale 1ns / 1ps

module can_bts_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [can_bts_pkg::DIV_W-1:0]   dividend_i,
  input  logic [can_bts_pkg::DIV_W-1:0]   divisor_i,
  output logic                            busy_o,
  output logic [can_bts_pkg::DIV_W-1:0]   quotient_o,
  output logic [can_bts_pkg::DIV_W-1:0]   remainder_o
);

  localparam int unsigned W     = can_bts_pkg::DIV_W;
  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(W - 1);

  logic [W-1:0]     quo_q, rem_q, dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [W:0]       trial;
  logic [W+1:0]     diff;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign trial = {rem_q, quo_q[W-1]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_q};

  // Control: busy for one cycle per quotient bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits shift in from the right as dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      if (!diff[W+1]) begin
        rem_q <= diff[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b1};
      end else begin
        rem_q <= trial[W-1:0];
        quo_q <= {quo_q[W-2:0], 1'b0};
      end
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

// File: rtl/core/can_bts_datapath.sv
`timescale 1ns / 1ps

module can_bts_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [can_bts_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [can_bts_pkg::CLK_W-1:0]        cfg_data_i,
  input  logic [can_bts_pkg::RATE_W-1:0]       bit_rate_i,
  input  logic [can_bts_pkg::SP_W-1:0]         wanted_sp_i,
  input  can_bts_pkg::cmd_t                    cmd_i,
  output can_bts_pkg::status_t                 status_o,
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output logic                                 out_found_o,
  output logic [can_bts_pkg::PRE_W-1:0]        out_prescaler_o,
  output logic [can_bts_pkg::SEG1_W-1:0]       out_seg1_o,
  output logic [can_bts_pkg::SEG2_W-1:0]       out_seg2_o,
  output logic [can_bts_pkg::SJW_W-1:0]        out_jump_width_o,
  output logic [can_bts_pkg::SP_W-1:0]         out_sample_point_o
);

  localparam int unsigned DW = can_bts_pkg::DIV_W;

  // Configuration registers
  logic [can_bts_pkg::CLK_W-1:0]  clock_freq_q;
  logic [can_bts_pkg::PRE_W-1:0]  presc_limit_q;
  logic [can_bts_pkg::SEG1_W-1:0] seg1_limit_q;
  logic [can_bts_pkg::SEG2_W-1:0] seg2_limit_q;
  logic [can_bts_pkg::SJW_W-1:0]  sjw_limit_q;

  // Search state
  logic [can_bts_pkg::RATE_W-1:0] rate_q;
  logic [can_bts_pkg::SP_W-1:0]   sp_q;
  logic [11:0]                    p_q;
  logic [35:0]                    denom_q;
  logic [9:0]                     total_q;
  logic [19:0]                    prod_q;
  logic [9:0]                     s2_q;

  logic            out_valid_q;
  logic            out_found_q;
  logic [can_bts_pkg::PRE_W-1:0]  out_p_q;
  logic [can_bts_pkg::SEG1_W-1:0] out_s1_q;
  logic [can_bts_pkg::SEG2_W-1:0] out_s2_q;
  logic [can_bts_pkg::SJW_W-1:0]  out_sjw_q;
  logic [can_bts_pkg::SP_W-1:0]   out_sp_q;

  logic [DW-1:0] div_a, div_b, quo, rem;
  logic          div_busy;
  logic [9:0]    s1;
  logic [19:0]   asp_num;
  logic [19:0]   prod_d;
  logic [39:0]   s2_prod;
  logic [9:0]    s2_quo;
  logic [7:0]    sjw;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_freq_q  <= can_bts_pkg::CLOCK_FREQ_RST;
      presc_limit_q <= can_bts_pkg::PRESC_LIMIT_RST;
      seg1_limit_q  <= can_bts_pkg::SEG1_LIMIT_RST;
      seg2_limit_q  <= can_bts_pkg::SEG2_LIMIT_RST;
      sjw_limit_q   <= can_bts_pkg::SJW_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        can_bts_pkg::REG_CLOCK_FREQ:  clock_freq_q  <= cfg_data_i;
        can_bts_pkg::REG_PRESC_LIMIT: presc_limit_q <= cfg_data_i[can_bts_pkg::PRE_W-1:0];
        can_bts_pkg::REG_SEG1_LIMIT:  seg1_limit_q  <= cfg_data_i[can_bts_pkg::SEG1_W-1:0];
        can_bts_pkg::REG_SEG2_LIMIT:  seg2_limit_q  <= cfg_data_i[can_bts_pkg::SEG2_W-1:0];
        can_bts_pkg::REG_SJW_LIMIT:   sjw_limit_q   <= cfg_data_i[can_bts_pkg::SJW_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived candidate values
  assign s1      = total_q - 10'd1 - s2_q;
  assign asp_num = {10'd0, can_bts_pkg::PERMILLE} * ({10'd0, s1} + 20'd1);
  assign prod_d  = {10'd0, total_q} * {10'd0, can_bts_pkg::PERMILLE - sp_q}
                   + can_bts_pkg::HALF_PERMILLE;
  assign sjw     = (s2_q < {2'b00, sjw_limit_q}) ? s2_q[7:0] : sjw_limit_q;

  // Divide the rounded product by 1000 with a reciprocal multiply
  assign s2_prod = {20'd0, prod_q} * {20'd0, can_bts_pkg::SEG_RECIP};
  assign s2_quo  = s2_prod[can_bts_pkg::SEG_SHIFT +: 10];

  // Select divider operands
  always_comb begin
    case (cmd_i.div_sel)
      can_bts_pkg::DIV_SEL_CLK: begin
        div_a = clock_freq_q;
        div_b = denom_q[DW-1:0];
      end
      can_bts_pkg::DIV_SEL_ASP: begin
        div_a = {10'd0, asp_num};
        div_b = {20'd0, total_q};
      end
      default: begin
        div_a = clock_freq_q;
        div_b = denom_q[DW-1:0];
      end
    endcase
  end

  can_bts_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (div_a),
    .divisor_i   (div_b),
    .busy_o      (div_busy),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // Hold the item and advance the prescaler search
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      rate_q  <= bit_rate_i;
      sp_q    <= wanted_sp_i;
      p_q     <= 12'd1;
      denom_q <= {12'd0, bit_rate_i};
    end else if (cmd_i.step) begin
      p_q     <= p_q + 12'd1;
      denom_q <= denom_q + {12'd0, rate_q};
    end
    if (cmd_i.load_total) begin
      total_q <= quo[9:0];
    end
    if (cmd_i.load_prod) begin
      prod_q <= prod_d;
    end
    if (cmd_i.load_s2) begin
      s2_q <= (s2_quo == '0) ? 10'd1 : s2_quo;
    end
  end

  // Status back to the controller
  always_comb begin
    status_o.reject     = (rate_q == '0)
                       || (clock_freq_q < {6'd0, rate_q})
                       || (sp_q < can_bts_pkg::SP_MIN)
                       || (sp_q > can_bts_pkg::SP_MAX);
    status_o.p_over     = p_q > {1'b0, presc_limit_q};
    status_o.denom_over = denom_q > {6'd0, clock_freq_q};
    status_o.div_busy   = div_busy;
    status_o.exact      = rem == '0;
    status_o.tot_small  = quo < can_bts_pkg::MIN_QUANTA;
    status_o.tot_big    = quo >= can_bts_pkg::QUANTA_CAP;
    status_o.seg_bad    = ({1'b0, total_q} < ({1'b0, s2_q} + 11'd2))
                       || (s1 > {1'b0, seg1_limit_q})
                       || (s2_q > {2'b00, seg2_limit_q});
    status_o.out_full   = out_valid_q && !out_ready_i;
  end

  // Output register: a new result loads once the previous beat is gone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_found_q <= cmd_i.push_found;
      if (cmd_i.push_found) begin
        out_p_q   <= p_q[can_bts_pkg::PRE_W-1:0];
        out_s1_q  <= s1[can_bts_pkg::SEG1_W-1:0];
        out_s2_q  <= s2_q[can_bts_pkg::SEG2_W-1:0];
        out_sjw_q <= sjw;
        out_sp_q  <= quo[can_bts_pkg::SP_W-1:0];
      end else begin
        out_p_q   <= '0;
        out_s1_q  <= '0;
        out_s2_q  <= '0;
        out_sjw_q <= '0;
        out_sp_q  <= '0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_found_o        = out_found_q;
  assign out_prescaler_o    = out_p_q;
  assign out_seg1_o         = out_s1_q;
  assign out_seg2_o         = out_s2_q;
  assign out_jump_width_o   = out_sjw_q;
  assign out_sample_point_o = out_sp_q;

endmodule

// File: rtl/core/can_bts_ctrl.sv
`timescale 1ns / 1ps

module can_bts_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  can_bts_pkg::status_t  status_i,
  output can_bts_pkg::cmd_t     cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SCREEN   = 4'd1;
  localparam logic [3:0] S_TRIAL    = 4'd2;
  localparam logic [3:0] S_DIV_CLK  = 4'd3;
  localparam logic [3:0] S_MUL      = 4'd4;
  localparam logic [3:0] S_SEG      = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd7;
  localparam logic [3:0] S_DIV_ASP  = 4'd8;
  localparam logic [3:0] S_NEXT     = 4'd9;
  localparam logic [3:0] S_OUT_OK   = 4'd10;
  localparam logic [3:0] S_OUT_FAIL = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Sequence one prescaler trial after another
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_SCREEN;
        end
      end
      S_SCREEN: begin
        state_d = status_i.reject ? S_OUT_FAIL : S_TRIAL;
      end
      S_TRIAL: begin
        if (status_i.p_over || status_i.denom_over) begin
          state_d = S_OUT_FAIL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = can_bts_pkg::DIV_SEL_CLK;
          state_d         = S_DIV_CLK;
        end
      end
      S_DIV_CLK: begin
        if (!status_i.div_busy) begin
          if (!status_i.exact || status_i.tot_big) begin
            state_d = S_NEXT;
          end else if (status_i.tot_small) begin
            state_d = S_OUT_FAIL;
          end else begin
            cmd_o.load_total = 1'b1;
            state_d          = S_MUL;
          end
        end
      end
      S_MUL: begin
        cmd_o.load_prod = 1'b1;
        state_d         = S_SEG;
      end
      S_SEG: begin
        cmd_o.load_s2 = 1'b1;
        state_d       = S_CHECK;
      end
      S_CHECK: begin
        if (status_i.seg_bad) begin
          state_d = S_NEXT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = can_bts_pkg::DIV_SEL_ASP;
          state_d         = S_DIV_ASP;
        end
      end
      S_DIV_ASP: begin
        if (!status_i.div_busy) begin
          state_d = S_OUT_OK;
        end
      end
      S_NEXT: begin
        cmd_o.step = 1'b1;
        state_d    = S_TRIAL;
      end
      S_OUT_OK: begin
        if (!status_i.out_full) begin
          cmd_o.push       = 1'b1;
          cmd_o.push_found = 1'b1;
          state_d          = S_IDLE;
        end
      end
      S_OUT_FAIL: begin
        if (!status_i.out_full) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/can_bit_timing_solver_top.sv
`timescale 1ns / 1ps
// CAN bit timing solver.
// Slave stream: one beat carries a requested bitrate and sample point; the
// block answers each beat with exactly one master beat holding the found
// flag (tuser) and the prescaler, segments, jump width and sample point.
// Configuration channel: cfg_index_i selects clock_freq, prescaler_limit,
// seg1_limit, seg2_limit or jump_width_limit; it is always ready. The user
// must write it only while no request is in flight; the block itself does
// not enforce this. The block walks prescalers 1, 2, ... and runs a
// restoring divide (clock / (prescaler * bitrate)) per trial. An exact
// candidate then gets its segment split, and the one that fits gets a sample
// point divide; a rejected request is answered from the screening state
// without any divide. Throughput is one request at a time.
// The result sits in an output register, so the next request is taken as
// soon as the result is loaded, even while the receiver stalls; a second
// result then waits until that beat is taken.
// Reset clears the state machine, the output valid and restores the
// configuration registers to 48 MHz, 1024, 16, 8 and 4.

module can_bit_timing_solver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [29:0] cfg_data_i,
  // Request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // bit_rate[23:0], wanted_sample_point[33:24]
  // Result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [47:0] m_axis_tdata_o,  // prescaler[10:0], seg1[19:11], seg2[27:20],
                                       // jump_width[35:28], achieved_sample_point[45:36]
  output logic        m_axis_tuser_o   // found[0]
);

  can_bts_pkg::cmd_t    cmd;
  can_bts_pkg::status_t status;

  logic [10:0] prescaler;
  logic [8:0]  seg1;
  logic [7:0]  seg2;
  logic [7:0]  jump_width;
  logic [9:0]  sample_point;

  assign cfg_ready_o = 1'b1;

  can_bts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  can_bts_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .bit_rate_i         (s_axis_tdata_i[23:0]),
    .wanted_sp_i        (s_axis_tdata_i[33:24]),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (m_axis_tready_i),
    .out_valid_o        (m_axis_tvalid_o),
    .out_found_o        (m_axis_tuser_o),
    .out_prescaler_o    (prescaler),
    .out_seg1_o         (seg1),
    .out_seg2_o         (seg2),
    .out_jump_width_o   (jump_width),
    .out_sample_point_o (sample_point)
  );

  // Pack the result beat
  assign m_axis_tdata_o = {2'b00, sample_point, jump_width, seg2, seg1, prescaler};

`ifndef ASSERT_OFF
  // A taken request keeps the solver busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request taken while a search was starting");

  // A not-found beat carries all-zero fields
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (m_axis_tdata_o == 48'd0))
    else $error("not-found result with nonzero fields");

  // A found beat has a real prescaler and a sample point within the bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      ((m_axis_tdata_o[10:0] != 11'd0) && (m_axis_tdata_o[45:36] <= 10'd1000)))
    else $error("found result with bad prescaler or sample point");

  // Jump width never exceeds phase segment 2
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o[35:28] <= m_axis_tdata_o[27:20]))
    else $error("jump width above phase segment 2");
`endif

endmodule

// File: sim/tb_can_bit_timing_solver_top.sv
`timescale 1ns / 1ps

// One solved bit timing, as carried by a result beat
typedef struct packed {
  logic                           found;
  logic [can_bts_pkg::PRE_W-1:0]  prescaler;
  logic [can_bts_pkg::SEG1_W-1:0] seg1;
  logic [can_bts_pkg::SEG2_W-1:0] seg2;
  logic [can_bts_pkg::SJW_W-1:0]  jump_width;
  logic [can_bts_pkg::SP_W-1:0]   sample_point;
} timing_t;

class timing_scoreboard;
  localparam longint unsigned SP_LOWEST      = 500;
  localparam longint unsigned SP_HIGHEST     = 950;
  localparam longint unsigned PERMILLE_SCALE = 1000;
  localparam longint unsigned ROUND_HALF     = 500;
  localparam longint unsigned QUANTA_FLOOR   = 4;

  // Shadow copy of the configuration registers
  logic [can_bts_pkg::CLK_W-1:0]  clock_freq;
  logic [can_bts_pkg::PRE_W-1:0]  presc_limit;
  logic [can_bts_pkg::SEG1_W-1:0] seg1_limit;
  logic [can_bts_pkg::SEG2_W-1:0] seg2_limit;
  logic [can_bts_pkg::SJW_W-1:0]  sjw_limit;

  timing_t     expected_timings[$];
  int unsigned fails;

  function new();
    clock_freq  = can_bts_pkg::CLOCK_FREQ_RST;
    presc_limit = can_bts_pkg::PRESC_LIMIT_RST;
    seg1_limit  = can_bts_pkg::SEG1_LIMIT_RST;
    seg2_limit  = can_bts_pkg::SEG2_LIMIT_RST;
    sjw_limit   = can_bts_pkg::SJW_LIMIT_RST;
    fails       = 0;
  endfunction

  function void write_reg(logic [can_bts_pkg::CFG_IDX_W-1:0] idx,
                          logic [can_bts_pkg::CLK_W-1:0] data);
    case (idx)
      can_bts_pkg::REG_CLOCK_FREQ:  clock_freq  = data;
      can_bts_pkg::REG_PRESC_LIMIT: presc_limit = data[can_bts_pkg::PRE_W-1:0];
      can_bts_pkg::REG_SEG1_LIMIT:  seg1_limit  = data[can_bts_pkg::SEG1_W-1:0];
      can_bts_pkg::REG_SEG2_LIMIT:  seg2_limit  = data[can_bts_pkg::SEG2_W-1:0];
      can_bts_pkg::REG_SJW_LIMIT:   sjw_limit   = data[can_bts_pkg::SJW_W-1:0];
      default: ;
    endcase
  endfunction

  // Walk prescalers upward and take the first exact one whose segments fit
  function timing_t solve_timing(logic [can_bts_pkg::RATE_W-1:0] rate,
                                 logic [can_bts_pkg::SP_W-1:0] sp);
    timing_t         t;
    longint unsigned clk;
    longint unsigned denom;
    longint unsigned total;
    longint unsigned s1;
    longint unsigned s2;
    longint unsigned jw;
    longint unsigned asp;
    int unsigned     p;
    t = '0;
    clk = clock_freq;
    if (rate == 0 || clk < rate || sp < SP_LOWEST || sp > SP_HIGHEST) return t;
    for (p = 1; p <= presc_limit; p++) begin
      denom = p;
      denom = denom * rate;
      if (clk % denom != 0) continue;
      total = clk / denom;
      if (total < QUANTA_FLOOR) break;
      s2 = (total * (PERMILLE_SCALE - sp) + ROUND_HALF) / PERMILLE_SCALE;
      if (s2 < 1) s2 = 1;
      if (total < s2 + 2) continue;
      s1 = total - 1 - s2;
      if (s1 > seg1_limit || s2 > seg2_limit) continue;
      jw  = (s2 < sjw_limit) ? s2 : sjw_limit;
      asp = (PERMILLE_SCALE * (1 + s1)) / total;
      t.found        = 1'b1;
      t.prescaler    = p[can_bts_pkg::PRE_W-1:0];
      t.seg1         = s1[can_bts_pkg::SEG1_W-1:0];
      t.seg2         = s2[can_bts_pkg::SEG2_W-1:0];
      t.jump_width   = jw[can_bts_pkg::SJW_W-1:0];
      t.sample_point = asp[can_bts_pkg::SP_W-1:0];
      return t;
    end
    return t;
  endfunction

  function void note_request(logic [can_bts_pkg::RATE_W-1:0] rate,
                             logic [can_bts_pkg::SP_W-1:0] sp);
    expected_timings.push_back(solve_timing(rate, sp));
  endfunction

  function void flag(string msg);
    fails++;
    if (fails <= 10) $display("mismatch: %s", msg);
  endfunction

  function void compare(string field, longint unsigned want, longint unsigned got);
    if (want != got) flag($sformatf("%s expected %0d, got %0d", field, want, got));
  endfunction

  function void check_result(logic found, logic [47:0] tdata);
    timing_t want;
    timing_t got;
    if (expected_timings.size() == 0) begin
      flag("result beat with no request outstanding");
      return;
    end
    want = expected_timings.pop_front();
    got.found        = found;
    got.prescaler    = tdata[10:0];
    got.seg1         = tdata[19:11];
    got.seg2         = tdata[27:20];
    got.jump_width   = tdata[35:28];
    got.sample_point = tdata[45:36];
    compare("found", want.found, got.found);
    compare("prescaler", want.prescaler, got.prescaler);
    compare("seg1", want.seg1, got.seg1);
    compare("seg2", want.seg2, got.seg2);
    compare("jump_width", want.jump_width, got.jump_width);
    compare("sample_point", want.sample_point, got.sample_point);
  endfunction

  function int unsigned outstanding();
    return expected_timings.size();
  endfunction
endclass

module tb_can_bit_timing_solver_top;
  localparam int unsigned CYCLE_LIMIT = 40_000_000;
  localparam logic [can_bts_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int unsigned ALL_ONES    = 32'h3FFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [29:0] cfg_data_i;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [47:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;

  int unsigned tx_idle_pct = 24;
  int unsigned rx_idle_pct = 76;
  int unsigned cycle_count = 0;
  int unsigned clock_choices [8] = '{48000000, 80000000, 40000000, 24000000,
                                     16000000, 64000000, 36000000, 100000000};

  timing_scoreboard timing_sb = new();

  can_bit_timing_solver_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #6 clk_i = ~clk_i;

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99, 0) >= rx_idle_pct);
  end

  // Check every result beat
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      timing_sb.check_result(m_axis_tuser_o, m_axis_tdata_o);
    end
  end

  // Offer one request beat, idling first at random; returns at a falling edge
  task automatic send_request(input int unsigned rate, input int unsigned sp);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {6'b0, sp[can_bts_pkg::SP_W-1:0], rate[can_bts_pkg::RATE_W-1:0]};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    timing_sb.note_request(rate[can_bts_pkg::RATE_W-1:0], sp[can_bts_pkg::SP_W-1:0]);
    @(negedge clk_i);
  endtask

  // Hold off requests until every result is back, then let the block settle
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(negedge clk_i);
    while (timing_sb.outstanding() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
  endtask

  task automatic set_register(input logic [can_bts_pkg::CFG_IDX_W-1:0] idx,
                              input int unsigned data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[can_bts_pkg::CLK_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    timing_sb.write_reg(idx, data[can_bts_pkg::CLK_W-1:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_setting(input bit wide);
    int unsigned clk;
    clk = ($urandom_range(7, 0) == 0) ? $urandom_range(1000000000, 1)
                                       : clock_choices[$urandom_range(7, 0)];
    set_register(can_bts_pkg::REG_CLOCK_FREQ, clk);
    set_register(can_bts_pkg::REG_PRESC_LIMIT, wide ? 1024 : $urandom_range(64, 1));
    set_register(can_bts_pkg::REG_SEG1_LIMIT, $urandom_range(64, 2));
    set_register(can_bts_pkg::REG_SEG2_LIMIT, $urandom_range(32, 1));
    set_register(can_bts_pkg::REG_SJW_LIMIT, $urandom_range(32, 1));
  endtask

  // Mostly bitrates that divide the clock exactly, the rest noise
  task automatic random_request();
    longint unsigned clk;
    longint unsigned quanta;
    longint unsigned rate;
    int unsigned     lim;
    int unsigned     tries;
    bit              formed;
    int unsigned     sp;
    clk    = timing_sb.clock_freq;
    lim    = (timing_sb.presc_limit > 64) ? 64 : timing_sb.presc_limit;
    formed = 1'b0;
    rate   = 0;
    if (lim == 0) lim = 1;
    if ($urandom_range(4, 0) != 0) begin
      for (tries = 0; tries < 16 && !formed; tries++) begin
        quanta = $urandom_range(lim, 1);
        quanta = quanta * $urandom_range(40, 4);
        if (clk % quanta == 0 && clk / quanta < (1 << can_bts_pkg::RATE_W)) begin
          rate   = clk / quanta;
          formed = 1'b1;
        end
      end
    end
    if (!formed) rate = $urandom & 32'h00FF_FFFF;
    sp = ($urandom_range(7, 0) == 0) ? $urandom_range(1023, 0) : $urandom_range(950, 500);
    send_request(rate[31:0], sp);
  endtask

  initial begin
    int unsigned mode;
    int unsigned setting;
    int unsigned n;
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset configuration: typical rates, sample point edges, rejections
    send_request(500000, 875);
    send_request(1000000, 800);
    send_request(125000, 500);
    send_request(250000, 950);
    send_request(0, 875);
    send_request(16000000, 875);
    send_request(16777215, 1023);
    send_request(16777215, 875);
    send_request(500000, 499);
    send_request(500000, 951);
    send_request(500000, 0);
    send_request(1, 875);

    // Zero jump width limit
    wait_drained();
    set_register(can_bts_pkg::REG_SJW_LIMIT, 0);
    send_request(500000, 875);
    // Zero segment limits, one at a time
    wait_drained();
    set_register(can_bts_pkg::REG_SEG1_LIMIT, 0);
    set_register(can_bts_pkg::REG_SJW_LIMIT, 4);
    send_request(500000, 875);
    wait_drained();
    set_register(can_bts_pkg::REG_SEG1_LIMIT, 16);
    set_register(can_bts_pkg::REG_SEG2_LIMIT, 0);
    send_request(500000, 875);
    // Zero prescaler limit
    wait_drained();
    set_register(can_bts_pkg::REG_SEG2_LIMIT, 8);
    set_register(can_bts_pkg::REG_PRESC_LIMIT, 0);
    send_request(500000, 875);
    // Limits at register width
    wait_drained();
    set_register(can_bts_pkg::REG_PRESC_LIMIT, ALL_ONES);
    set_register(can_bts_pkg::REG_SEG1_LIMIT, ALL_ONES);
    set_register(can_bts_pkg::REG_SEG2_LIMIT, ALL_ONES);
    set_register(can_bts_pkg::REG_SJW_LIMIT, ALL_ONES);
    send_request(1000000, 875);
    send_request(100000, 700);
    // Largest clock
    wait_drained();
    set_register(can_bts_pkg::REG_CLOCK_FREQ, ALL_ONES);
    send_request(1000000, 875);
    send_request(4648233, 875);
    // Clock below the bitrate, and too few quanta
    wait_drained();
    set_register(can_bts_pkg::REG_CLOCK_FREQ, 1);
    send_request(2, 875);
    send_request(1, 875);
    // Unused index must leave everything alone
    wait_drained();
    set_register(REG_UNUSED, 32'h2AAA_AAAA);
    set_register(can_bts_pkg::REG_CLOCK_FREQ, 1000000000);
    send_request(1000000, 875);

    // Random settings under each idling mix
    for (mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 24 : (mode == 1) ? 76 : 0;
      rx_idle_pct = (mode == 0) ? 76 : (mode == 1) ? 24 : 0;
      for (setting = 0; setting < 3; setting++) begin
        wait_drained();
        random_setting(mode == 0 && setting == 1);
        for (n = 0; n < 9; n++) begin
          if (n == 5) wait_drained();
          random_request();
        end
      end
    end

    wait_drained();
    repeat (100) @(negedge clk_i);
    if (timing_sb.outstanding() != 0) timing_sb.flag("results still outstanding at end");
    if (timing_sb.fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
